/* hdl/ldef_pkg.sv */
// shared types and constants for the lru duplicate event filter
// no dependencies
`default_nettype none

package ldef_pkg;

	// register index of window_limit (paddr word select)
	localparam logic REG_WINDOW_LIMIT = 1'b0;
	localparam logic [4:0] WINDOW_LIMIT_RESET = 5'd16;

	typedef enum logic [1:0] {
		VERDICT_FRESH     = 2'd0,
		VERDICT_DUPLICATE = 2'd1,
		VERDICT_EXPIRED   = 2'd2,
		VERDICT_INVALID   = 2'd3
	} verdict_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SHIFT,
		ST_PUT,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

/* hdl/ldef_key_ram.sv */
// key window storage: one write port, one read port, registered read data
// no dependencies
`default_nettype none

module ldef_key_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 64,
	parameter int AW = 4
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

/* hdl/lru_duplicate_event_filter.sv */
// lru duplicate event filter: verdict per event from a window of recent keys
// invalid or expired items go from accept straight to the verdict; others take a scan pass
// over the held keys, then a shift pass on a hit or when the window is full
// one item at a time: next item taken the cycle after the verdict loads; the verdict waits for a free output register
// reset: window empty, window_limit 16, output empty; key memory is not cleared
// depends on ldef_pkg and ldef_key_ram
`default_nettype none

module lru_duplicate_event_filter #(
	parameter int WINDOW_DEPTH = 16,
	parameter int KEY_BITS = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// event input channel
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        parse_ok,
	input  wire logic [63:0] event_key,
	input  wire logic [63:0] expires_ms,
	input  wire logic [63:0] now_ms,
	// verdict output channel
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       verdict,
	// configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);

	// counter width holds 0..WINDOW_DEPTH, address width indexes the memory
	localparam int CW = $clog2(WINDOW_DEPTH + 1);
	localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

	ldef_pkg::state_t   state_q, state_d;
	ldef_pkg::verdict_t verdict_q, verdict_d;

	logic [KEY_BITS-1:0] key_q, key_d;
	logic [CW-1:0]       count_q, count_d;
	logic [CW-1:0]       idx_q, idx_d;
	logic [CW-1:0]       put_addr_q, put_d;
	logic [CW-1:0]       pidx_s1, pidx_d;
	logic [CW-1:0]       pidx_m1;
	logic                pend_s1, pend_d;
	logic [CW-1:0]       lim;
	logic                issue;

	logic [4:0] window_limit_q;

	logic                res_valid_q;
	logic [1:0]          res_verdict_q;
	logic                res_load;

	// memory port
	logic                rd_en;
	logic [AW-1:0]       rd_addr;
	logic [KEY_BITS-1:0] rd_data_s1;
	logic                wr_en;
	logic [AW-1:0]       wr_addr;
	logic [KEY_BITS-1:0] wr_data;

	ldef_key_ram #(
		.DEPTH (WINDOW_DEPTH),
		.WIDTH (KEY_BITS),
		.AW    (AW)
	) u_key_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data_s1)
	);

	// configuration register, clamped to 1..WINDOW_DEPTH where used
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_limit_q <= ldef_pkg::WINDOW_LIMIT_RESET;
		end else if (psel && penable && pwrite && paddr[2] == ldef_pkg::REG_WINDOW_LIMIT) begin
			window_limit_q <= pwdata[4:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == ldef_pkg::REG_WINDOW_LIMIT) begin
			prdata = {27'd0, window_limit_q};
		end
	end

	always_comb begin
		if (window_limit_q == 5'd0) begin
			lim = CW'(1);
		end else if (32'(window_limit_q) > WINDOW_DEPTH) begin
			lim = CW'(WINDOW_DEPTH);
		end else begin
			lim = CW'(window_limit_q);
		end
	end

	assign in_ready = (state_q == ldef_pkg::ST_IDLE);
	assign pidx_m1  = pidx_s1 - CW'(1);

	// sequencer: scan pass finds the key, shift pass closes the gap one entry a cycle,
	// then the key goes to the newest place (or is appended when there is room)
	always_comb begin
		state_d   = state_q;
		verdict_d = verdict_q;
		key_d     = key_q;
		count_d   = count_q;
		idx_d     = idx_q;
		put_d     = put_addr_q;
		pend_d    = 1'b0;
		pidx_d    = idx_q;
		issue     = idx_q < count_q;
		rd_en     = 1'b0;
		rd_addr   = idx_q[AW-1:0];
		wr_en     = 1'b0;
		wr_addr   = pidx_m1[AW-1:0];
		wr_data   = rd_data_s1;
		res_load  = 1'b0;
		unique case (state_q)
			ldef_pkg::ST_IDLE: begin
				if (in_valid) begin
					key_d = event_key[KEY_BITS-1:0];
					idx_d = '0;
					if (!parse_ok) begin
						verdict_d = ldef_pkg::VERDICT_INVALID;
						state_d   = ldef_pkg::ST_DONE;
					end else if (now_ms != 64'd0 && expires_ms <= now_ms) begin
						verdict_d = ldef_pkg::VERDICT_EXPIRED;
						state_d   = ldef_pkg::ST_DONE;
					end else begin
						state_d = ldef_pkg::ST_SCAN;
					end
				end
			end
			ldef_pkg::ST_SCAN: begin
				// read one entry a cycle, compare it the cycle after
				rd_en  = issue;
				pend_d = issue;
				if (issue) begin
					idx_d = idx_q + CW'(1);
				end
				if (pend_s1 && rd_data_s1 == key_q) begin
					// hit: shift the entries above it down, key goes last
					verdict_d = ldef_pkg::VERDICT_DUPLICATE;
					idx_d     = pidx_s1 + CW'(1);
					pend_d    = 1'b0;
					rd_en     = 1'b0;
					state_d   = ldef_pkg::ST_SHIFT;
				end else if (!issue) begin
					verdict_d = ldef_pkg::VERDICT_FRESH;
					pend_d    = 1'b0;
					if (count_q < lim) begin
						put_d   = count_q;
						count_d = count_q + CW'(1);
						state_d = ldef_pkg::ST_PUT;
					end else begin
						// full: evict the oldest by shifting everything down
						idx_d   = CW'(1);
						state_d = ldef_pkg::ST_SHIFT;
					end
				end
			end
			ldef_pkg::ST_SHIFT: begin
				// read entry j, write it to j-1 the next cycle
				rd_en  = issue;
				pend_d = issue;
				if (issue) begin
					idx_d = idx_q + CW'(1);
				end
				if (pend_s1) begin
					wr_en = 1'b1;
				end
				if (!issue && !pend_s1) begin
					put_d   = count_q - CW'(1);
					state_d = ldef_pkg::ST_PUT;
				end
			end
			ldef_pkg::ST_PUT: begin
				wr_en   = 1'b1;
				wr_addr = put_addr_q[AW-1:0];
				wr_data = key_q;
				state_d = ldef_pkg::ST_DONE;
			end
			ldef_pkg::ST_DONE: begin
				// hand the verdict to the output register once it is free
				if (!res_valid_q || out_ready) begin
					res_load = 1'b1;
					state_d  = ldef_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ldef_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ldef_pkg::ST_IDLE;
			count_q <= '0;
			idx_q   <= '0;
			pend_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			idx_q   <= idx_d;
			pend_s1 <= pend_d;
		end
	end

	always_ff @(posedge clk) begin
		verdict_q  <= verdict_d;
		key_q      <= key_d;
		put_addr_q <= put_d;
		pidx_s1    <= pidx_d;
	end

	// output register: next item can be taken while a verdict waits here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (out_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_verdict_q <= verdict_q;
		end
	end

	assign out_valid = res_valid_q;
	assign verdict   = res_verdict_q;

endmodule

`default_nettype wire

/* tb/sv/tb_lru_duplicate_event_filter.sv */
// self-checking testbench for lru_duplicate_event_filter: random and directed events,
// verdicts checked in order against a local model of the recent-key window
// depends on ldef_pkg and the lru_duplicate_event_filter rtl
`timescale 1ns / 1ps

module tb_lru_duplicate_event_filter;

	localparam int WINDOW_DEPTH = 16;
	localparam int KEY_POOL_SIZE = 32;
	localparam int PHASE_EVENTS = 155;
	localparam int STALL_LIMIT = 2000;
	localparam int MAX_PRINTED = 40;
	localparam logic [2:0] LIMIT_ADDR = 3'(4 * ldef_pkg::REG_WINDOW_LIMIT);

	typedef struct packed {
		logic        parse_ok;
		logic [63:0] event_key;
		logic [63:0] expires_ms;
		logic [63:0] now_ms;
	} event_t;

	// dut signals, inputs known from time zero
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        parse_ok = 1'b0;
	logic [63:0] event_key = '0;
	logic [63:0] expires_ms = '0;
	logic [63:0] now_ms = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  verdict;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// stimulus and scoreboard state
	event_t              pending_events[$];
	ldef_pkg::verdict_t  expected_verdicts[$];
	event_t      in_flight;
	int          queued_total = 0;
	int          accepted_total = 0;
	int          mismatches = 0;
	int          idle_cycles = 0;
	int          gap_left = 0;
	int          stall_left = 0;
	bit          sender_idle_en = 1'b1;
	bit          sink_idle_en = 1'b1;
	bit          drain_hold = 1'b0;
	logic [63:0] key_pool[KEY_POOL_SIZE];

	// local copy of the window and of the limit register
	logic [63:0] window_keys[WINDOW_DEPTH];
	int          window_count = 0;
	logic [4:0]  window_limit_reg = ldef_pkg::WINDOW_LIMIT_RESET;

	lru_duplicate_event_filter uut (.*);

	initial begin
		forever #2 clk = ~clk;
	end

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= MAX_PRINTED)
			$display("mismatch @%0t: %s", $realtime, what);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int effective_limit();
		if (window_limit_reg == 5'd0)
			return 1;
		if (window_limit_reg > WINDOW_DEPTH)
			return WINDOW_DEPTH;
		return window_limit_reg;
	endfunction

	// verdict for one accepted event; updates the local window as the block would
	function ldef_pkg::verdict_t predict_verdict(input event_t ev);
		int hit;
		int lim;
		hit = -1;
		lim = effective_limit();
		if (!ev.parse_ok)
			return ldef_pkg::VERDICT_INVALID;
		if (ev.now_ms != 64'd0 && ev.expires_ms <= ev.now_ms)
			return ldef_pkg::VERDICT_EXPIRED;
		for (int i = 0; i < window_count; i++)
			if (hit < 0 && window_keys[i] == ev.event_key)
				hit = i;
		if (hit >= 0) begin
			// hit: close the gap and move the key to the newest slot
			for (int i = hit + 1; i < window_count; i++)
				window_keys[i - 1] = window_keys[i];
			window_keys[window_count - 1] = ev.event_key;
			return ldef_pkg::VERDICT_DUPLICATE;
		end
		if (window_count < lim) begin
			window_keys[window_count] = ev.event_key;
			window_count++;
			return ldef_pkg::VERDICT_FRESH;
		end
		// full, or limit lowered below the count: drop only the oldest key
		for (int i = 1; i < window_count; i++)
			window_keys[i - 1] = window_keys[i];
		window_keys[window_count - 1] = ev.event_key;
		return ldef_pkg::VERDICT_FRESH;
	endfunction

	task automatic queue_event(input logic p, input logic [63:0] k, input logic [63:0] e,
			input logic [63:0] n);
		event_t ev;
		ev.parse_ok = p;
		ev.event_key = k;
		ev.expires_ms = e;
		ev.now_ms = n;
		pending_events.push_back(ev);
		queued_total++;
	endtask

	// mostly well-formed live events over a small key pool, with some noise
	task automatic queue_random_events(input int count, input int pool_size);
		logic        p;
		logic [63:0] k;
		logic [63:0] e;
		logic [63:0] n;
		logic [63:0] d;
		int          r;
		repeat (count) begin
			p = ($urandom_range(0, 99) < 92);
			k = ($urandom_range(0, 3) != 0) ? key_pool[$urandom_range(0, pool_size - 1)]
				: rand64();
			r = $urandom_range(0, 99);
			n = (r < 12) ? 64'd0 : (r < 16) ? '1 : rand64();
			d = 64'($urandom_range(0, 1000));
			r = $urandom_range(0, 99);
			if (r < 80) begin
				// still live, unless now is already at the top of the range
				e = n + 64'd1 + d;
				if (e <= n)
					e = '1;
			end else if (r < 95) begin
				e = (n > d) ? n - d : 64'd0;
			end else begin
				e = rand64();
			end
			queue_event(p, k, e, n);
		end
	endtask

	// one apb transfer, started at a clock edge; waits out pready, then releases the bus
	task automatic apb_transfer(input logic wr, input logic [31:0] wdata,
			output logic [31:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= LIMIT_ADDR;
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (wr)
			window_limit_reg = wdata[4:0];
		@(posedge clk);
	endtask

	task automatic check_limit_readback();
		logic [31:0] rdata;
		apb_transfer(1'b0, 32'd0, rdata);
		if (rdata !== {27'd0, window_limit_reg})
			report_mismatch($sformatf("window_limit reads %0h, expected %0h",
				rdata, window_limit_reg));
	endtask

	// block is idle once every queued item is taken and every verdict is back
	task automatic wait_drained();
		while (accepted_total != queued_total || expected_verdicts.size() != 0)
			@(posedge clk);
	endtask

	// driver: presents queued items, gaps between them, and the drain pause
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				expected_verdicts.push_back(predict_verdict(in_flight));
				accepted_total++;
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_events.size() != 0 &&
						!(drain_hold && expected_verdicts.size() != 0)) begin
					in_flight = pending_events.pop_front();
					parse_ok <= in_flight.parse_ok;
					event_key <= in_flight.event_key;
					expires_ms <= in_flight.expires_ms;
					now_ms <= in_flight.now_ms;
					in_valid <= 1'b1;
					gap_left = sender_idle_en ? pick_gap() : 0;
					// now and then hold the next item until the block has fully drained
					drain_hold = ($urandom_range(0, 99) == 0) || (accepted_total == 100);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks each verdict against the oldest expectation, stalls the sink
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_verdicts.size() == 0)
					report_mismatch($sformatf("verdict %0d with no item pending", verdict));
				else if (verdict !== expected_verdicts[0]) begin
					report_mismatch($sformatf("verdict %0d, expected %s", verdict,
						expected_verdicts[0].name()));
					void'(expected_verdicts.pop_front());
				end else begin
					void'(expected_verdicts.pop_front());
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (sink_idle_en && $urandom_range(0, 3) == 0) begin
				stall_left = pick_gap();
				out_ready <= (stall_left == 0);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// progress counter for the watchdog
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		while (idle_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("tb_lru_duplicate_event_filter NOT OK");
		$finish;
	end

	initial begin
		int phase_limits[10];
		int pool_size;
		logic [31:0] rdata;
		logic [63:0] key_a;
		logic [63:0] key_b;
		logic [63:0] key_c;
		logic [63:0] key_d;
		// 16 fills the window, then 4 lowers it below the count; 0 and 31 clamp
		phase_limits = '{16, 4, 0, 31, 1, 16, 3, 9, 16, 7};
		key_pool[0] = 64'd0;
		key_pool[1] = '1;
		for (int i = 2; i < KEY_POOL_SIZE; i++)
			key_pool[i] = rand64();
		key_a = key_pool[2];
		key_b = key_pool[3];
		key_c = key_pool[4];
		key_d = key_pool[5];

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		check_limit_readback();

		// directed: parse failure wins over everything
		queue_event(1'b0, 64'd0, 64'd0, 64'd0);
		queue_event(1'b0, key_a, 64'd5, 64'd10);
		queue_event(1'b0, '1, '1, '1);
		// now of zero skips the expiry check
		queue_event(1'b1, key_a, 64'd0, 64'd0);
		queue_event(1'b1, key_a, 64'd0, 64'd0);
		// expiry at, before, and just after now
		queue_event(1'b1, key_b, '1, '1);
		queue_event(1'b1, key_b, 64'd100, 64'd100);
		queue_event(1'b1, key_b, 64'd99, 64'd100);
		queue_event(1'b1, key_b, 64'd101, 64'd100);
		queue_event(1'b1, 64'd0, '1, 64'd1);
		queue_event(1'b1, '1, '1, 64'd1);
		queue_event(1'b1, 64'd0, '1, 64'd1);
		// expired or invalid events leave the window alone
		queue_event(1'b1, key_a, 64'd1, 64'd2);
		queue_event(1'b1, key_a, 64'd3, 64'd2);
		queue_event(1'b0, key_c, 64'd3, 64'd2);
		queue_event(1'b1, key_c, 64'd3, 64'd2);
		queue_event(1'b1, key_d, 64'd0, '1);
		queue_event(1'b1, key_d, '1, 64'd0);
		// key a moved to newest earlier, so b is now the oldest
		queue_event(1'b1, key_b, '1, 64'd7);
		queue_event(1'b1, key_a, '1, 64'd7);
		wait_drained();

		for (int p = 0; p < 10; p++) begin
			// random upper bits in the write data must be dropped by the register
			apb_transfer(1'b1, {27'($urandom_range(0, 32'h07ff_ffff)),
				5'(phase_limits[p])}, rdata);
			check_limit_readback();
			sender_idle_en = (p % 3 != 1);
			sink_idle_en = (p % 4 != 2);
			pool_size = effective_limit() + $urandom_range(1, 10);
			if (p == 8)
				pool_size = KEY_POOL_SIZE;
			queue_random_events(PHASE_EVENTS, pool_size);
			wait_drained();
		end

		// latency margin for stray results
		repeat (60) @(posedge clk);
		if (expected_verdicts.size() != 0)
			report_mismatch($sformatf("%0d verdicts never arrived", expected_verdicts.size()));
		if (mismatches == 0)
			$display("tb_lru_duplicate_event_filter OK");
		else
			$display("tb_lru_duplicate_event_filter NOT OK");
		$finish;
	end

endmodule

/* lru_duplicate_event_filter.f */
hdl/ldef_pkg.sv
hdl/ldef_key_ram.sv
hdl/lru_duplicate_event_filter.sv
tb/sv/tb_lru_duplicate_event_filter.sv
